>>> src/dlp_pkg.sv
// Package with the shared types and constants of the decimal line parser.
package dlp_pkg;

    localparam int LINE_CHARS_DEF = 32;
    localparam int VALUE_W = 16;
    localparam int BYTE_W = 8;
    localparam int SUM_W = VALUE_W + 4;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_TRAIL,
        PH_FAIL
    } phase_t;

endpackage

>>> src/decimal_line_parser_u16_top.sv
// A carriage return beat passes the input register and then the result register.
// Throughput: one byte per cycle; only a carriage return waits on a stalled result register.
// The input register and the result register part the two channels, so bytes keep
// flowing while a finished result waits to be taken.
// Reset is synchronous and active low; it empties both registers and clears the line state.
// Top level of the decimal line parser: input register, line state and result register.
module decimal_line_parser_u16_top #(
    parameter int LINE_CHARS = dlp_pkg::LINE_CHARS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dlp_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dlp_pkg::VALUE_W-1:0] m_parsed_value,
    output logic                        m_nonblank,
    output logic                        m_line_ok
);

    localparam int KEPT_W = $clog2(LINE_CHARS);
    localparam logic [KEPT_W-1:0] KEPT_LIMIT = KEPT_W'(LINE_CHARS - 1);

    logic                        in_valid_reg, in_valid_next;
    logic [dlp_pkg::BYTE_W-1:0]  in_byte_reg, in_byte_next;
    dlp_pkg::phase_t             phase_reg, phase_next;
    logic [dlp_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [KEPT_W-1:0]           kept_reg, kept_next;
    logic                        ended_reg, ended_next;
    logic                        m_valid_reg, m_valid_next;
    logic [dlp_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        has_reg, has_next;
    logic                        ok_reg, ok_next;

    logic                        out_free;
    logic                        is_cr;
    logic                        consume;
    logic                        is_blank;
    logic                        is_digit;
    logic [dlp_pkg::SUM_W-1:0]   acc_wide;
    logic [dlp_pkg::SUM_W-1:0]   digit_sum;
    logic                        res_ok;
    logic                        res_has;
    logic [dlp_pkg::VALUE_W-1:0] res_value;

    assign out_free = !m_valid_reg || m_ready;
    assign is_cr = (in_byte_reg == dlp_pkg::CH_CR);
    assign consume = in_valid_reg && (!is_cr || out_free);
    assign s_ready = !in_valid_reg || consume;

    assign is_blank = (in_byte_reg == dlp_pkg::CH_SPACE) || (in_byte_reg == dlp_pkg::CH_TAB);
    assign is_digit = (in_byte_reg >= dlp_pkg::CH_ZERO) && (in_byte_reg <= dlp_pkg::CH_NINE);
    assign acc_wide = {4'b0000, acc_reg};
    assign digit_sum = (acc_wide << 3) + (acc_wide << 1)
                     + {{(dlp_pkg::SUM_W - 4){1'b0}}, in_byte_reg[3:0]};

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next = s_rx_byte;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        kept_next = kept_reg;
        ended_next = ended_reg;
        if (consume) begin
            if (is_cr) begin
                phase_next = dlp_pkg::PH_LEAD;
                acc_next = '0;
                kept_next = '0;
                ended_next = 1'b0;
            end else if (in_byte_reg != dlp_pkg::CH_LF && kept_reg < KEPT_LIMIT) begin
                kept_next = kept_reg + 1'b1;
                if (!ended_reg) begin
                    if (in_byte_reg == dlp_pkg::CH_NUL) begin
                        ended_next = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            dlp_pkg::PH_LEAD: begin
                                if (is_digit) begin
                                    acc_next = {{(dlp_pkg::VALUE_W - 4){1'b0}}, in_byte_reg[3:0]};
                                    phase_next = dlp_pkg::PH_DIGITS;
                                end else if (!is_blank) begin
                                    phase_next = dlp_pkg::PH_FAIL;
                                end
                            end
                            dlp_pkg::PH_DIGITS: begin
                                if (is_digit) begin
                                    if (digit_sum[dlp_pkg::SUM_W-1:dlp_pkg::VALUE_W] != '0) begin
                                        phase_next = dlp_pkg::PH_FAIL;
                                    end else begin
                                        acc_next = digit_sum[dlp_pkg::VALUE_W-1:0];
                                    end
                                end else if (is_blank) begin
                                    phase_next = dlp_pkg::PH_TRAIL;
                                end else begin
                                    phase_next = dlp_pkg::PH_FAIL;
                                end
                            end
                            dlp_pkg::PH_TRAIL: begin
                                if (!is_blank) begin
                                    phase_next = dlp_pkg::PH_FAIL;
                                end
                            end
                            dlp_pkg::PH_FAIL: begin
                                phase_next = dlp_pkg::PH_FAIL;
                            end
                            default: begin
                                phase_next = dlp_pkg::PH_FAIL;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_comb begin
        res_ok = (phase_reg != dlp_pkg::PH_FAIL);
        res_has = (phase_reg != dlp_pkg::PH_LEAD);
        res_value = (res_ok && res_has) ? acc_reg : '0;
        m_valid_next = m_valid_reg;
        value_next = value_reg;
        has_next = has_reg;
        ok_next = ok_reg;
        if (consume && is_cr) begin
            m_valid_next = 1'b1;
            value_next = res_value;
            has_next = res_has;
            ok_next = res_ok;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg <= dlp_pkg::PH_LEAD;
            acc_reg <= '0;
            kept_reg <= '0;
            ended_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg <= phase_next;
            acc_reg <= acc_next;
            kept_reg <= kept_next;
            ended_reg <= ended_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        value_reg <= value_next;
        has_reg <= has_next;
        ok_reg <= ok_next;
    end

    assign m_valid = m_valid_reg;
    assign m_parsed_value = value_reg;
    assign m_nonblank = has_reg;
    assign m_line_ok = ok_reg;

endmodule

>>> src/dlp_checker.sv
// Port-level checker for the decimal line parser, bound to its top level.
module dlp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [dlp_pkg::BYTE_W-1:0]  s_rx_byte,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [dlp_pkg::VALUE_W-1:0] m_parsed_value,
    input logic                        m_nonblank,
    input logic                        m_line_ok
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result beat present right after reset.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parsed_value)
            && $stable(m_nonblank) && $stable(m_line_ok))
        else $error("Stalled result beat changed.");

    a_value_needs_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_parsed_value != '0) |-> m_line_ok && m_nonblank)
        else $error("Nonzero value on a failed or blank line.");

    a_blank_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_nonblank |-> m_line_ok)
        else $error("Blank line reported as failed.");

    a_result_from_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_rx_byte == dlp_pkg::CH_CR), 2))
        else $error("Result beat without a carriage return two cycles before.");

endmodule

bind decimal_line_parser_u16_top dlp_checker u_dlp_checker (.*);
